// ===== rtl/core/euler_rotation_matrix_unit_assert.svh =====
// assertion macros for the euler rotation matrix unit
// no dependencies
`ifndef EULER_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define EULER_ROTATION_MATRIX_UNIT_ASSERT_SVH
// assert that a property holds while out of reset
`define ERM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// assert a condition is followed next cycle by another
`define ERM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/erm_pkg.sv =====
// types and constants for the euler rotation matrix unit
// no dependencies
package erm_pkg;

  localparam int AngleFracBits = 6;
  localparam int OutFracBits   = 14;
  localparam logic [29:0] RadPerDeg = 30'd18740330;
  localparam logic [30:0] QOne = 31'h4000_0000;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] angle_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
  } erm_in_t;

  typedef struct packed {
    logic signed [15:0] col0_row0;
    logic signed [15:0] col0_row1;
    logic signed [15:0] col0_row2;
    logic signed [15:0] col1_row0;
    logic signed [15:0] col1_row1;
    logic signed [15:0] col1_row2;
    logic signed [15:0] col2_row0;
    logic signed [15:0] col2_row1;
    logic signed [15:0] col2_row2;
  } erm_out_t;

  // signed q30 value, magnitude up to one
  typedef logic signed [31:0] q30_t;

  // unsigned q30 product rounded half up (a, b magnitudes <= 1.0)
  function automatic logic [30:0] umulq(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = a * b + 62'(1 << 29);
    return p[60:30];
  endfunction

  // signed q30 product, rounded half away from zero
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic [30:0] ua, ub, m;
    ua = a[31] ? 31'(-a) : a[30:0];
    ub = b[31] ? 31'(-b) : b[30:0];
    m = umulq(ua, ub);
    return (a[31] ^ b[31]) ? -q30_t'({1'b0, m}) : q30_t'({1'b0, m});
  endfunction

  // q30 to output format, rounding half away from zero and saturating
  function automatic logic [15:0] to_out(input q30_t v);
    logic [30:0] u;
    logic [31:0] m;
    u = v[31] ? 31'(-v) : v[30:0];
    m = (32'(u) + 32'(1 << (29 - OutFracBits))) >> (30 - OutFracBits);
    if (m > 32'(1 << OutFracBits)) m = 32'(1 << OutFracBits);
    return v[31] ? 16'(-m) : m[15:0];
  endfunction

endpackage

// ===== rtl/core/erm_sincos.sv =====
// pipelined sine and cosine of one angle in degrees, q30 results
// depends on erm_pkg; 13 register stages with a shared enable
module erm_sincos (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic signed [15:0]  angle_i,
  output erm_pkg::q30_t       sin_o,
  output erm_pkg::q30_t       cos_o
);
  import erm_pkg::*;

  localparam int Full    = 360 << AngleFracBits;
  localparam int Quarter = 90 << AngleFracBits;
  localparam logic signed [16:0] FullS = 17'(Full);

  // exact division of a value below 2^30 by a constant k:
  // n / k == (n * ceil(2^(30+l) / k)) >> (30+l), with 2^l >= k
  localparam logic [30:0] Recip72 = 31'd1908874354;
  localparam int          Shift72 = 37;
  localparam logic [30:0] Recip42 = 31'd1636178018;
  localparam int          Shift42 = 36;
  localparam logic [30:0] Recip20 = 31'd1717986919;
  localparam int          Shift20 = 35;
  localparam logic [30:0] Recip6  = 31'd1431655766;
  localparam int          Shift6  = 33;
  localparam logic [30:0] Recip90 = 31'd1527099484;
  localparam int          Shift90 = 37;
  localparam logic [30:0] Recip56 = 31'd1227133514;
  localparam int          Shift56 = 36;
  localparam logic [30:0] Recip30 = 31'd1145324613;
  localparam int          Shift30 = 35;
  localparam logic [30:0] Recip12 = 31'd1431655766;
  localparam int          Shift12 = 34;

  // stage 1: wrap into [0, 360)
  logic signed [16:0] v;
  logic [14:0] a_d, a_q;
  // stage 2: quadrant, fold
  logic [1:0]  q_d;
  logic [12:0] r_rem;
  logic        fold_d;
  logic [12:0] r2_q;
  logic [1:0]  quad_q [2:12];
  logic        fold_q [2:12];
  // stage 3: radians, stage 4: square
  logic [43:0] xp;
  logic [59:0] x2p;
  logic [29:0] x_q  [3:11];
  logic [29:0] x2_q [4:11];
  // horner chains, product and divide on alternate stages
  logic [30:0] ts_q [4];
  logic [30:0] tc_q [4];
  logic [29:0] ps_q [1:3];
  logic [29:0] pc_q [1:3];
  // stage 12: sine product and last cosine step, stage 13: quadrant map
  logic [29:0] sv_q;
  logic [30:0] cv_q;
  q30_t        sin_q, cos_q;
  q30_t        s, c;

  // high word of a q30 product, values below 2^30 times at most one
  function automatic logic [29:0] qmul(input logic [29:0] a, input logic [30:0] b);
    logic [60:0] p;
    p = 61'(a) * 61'(b);
    return p[59:30];
  endfunction

  // one horner update: qone - n/k, n below 2^30
  function automatic logic [30:0] hupd(input logic [29:0] n, input logic [30:0] recip,
                                       input int sh);
    logic [60:0] p;
    p = 61'(n) * 61'(recip);
    return QOne - 31'(p >> sh);
  endfunction

  always_comb begin
    v = 17'(angle_i);
    if (v >= FullS) begin
      a_d = 15'(v - FullS);
    end else if (v >= 17'sd0) begin
      a_d = 15'(v);
    end else if (v >= -FullS) begin
      a_d = 15'(v + FullS);
    end else begin
      a_d = 15'(v + FullS + FullS);
    end
  end

  always_comb begin
    if (a_q >= 15'(3 * Quarter)) begin
      q_d = 2'd3; r_rem = 13'(a_q - 15'(3 * Quarter));
    end else if (a_q >= 15'(2 * Quarter)) begin
      q_d = 2'd2; r_rem = 13'(a_q - 15'(2 * Quarter));
    end else if (a_q >= 15'(Quarter)) begin
      q_d = 2'd1; r_rem = 13'(a_q - 15'(Quarter));
    end else begin
      q_d = 2'd0; r_rem = 13'(a_q);
    end
    fold_d = (14'(r_rem) << 1) > 14'(Quarter);
  end

  assign xp  = 44'(r2_q) * 44'(RadPerDeg);
  assign x2p = 60'(x_q[3]) * 60'(x_q[3]);

  always_comb begin
    s = fold_q[12] ? q30_t'({1'b0, cv_q}) : q30_t'({2'b0, sv_q});
    c = fold_q[12] ? q30_t'({2'b0, sv_q}) : q30_t'({1'b0, cv_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q       <= a_d;
      quad_q[2] <= q_d;
      fold_q[2] <= fold_d;
      r2_q      <= fold_d ? 13'(Quarter) - r_rem : r_rem;
      for (int i = 3; i <= 12; i++) begin
        quad_q[i] <= quad_q[i-1];
        fold_q[i] <= fold_q[i-1];
      end
      x_q[3] <= 30'(xp >> AngleFracBits);
      for (int i = 4; i <= 11; i++) x_q[i] <= x_q[i-1];
      x2_q[4] <= x2p[59:30];
      for (int i = 5; i <= 11; i++) x2_q[i] <= x2_q[i-1];
      // first step multiplies by one, so only the divide remains
      ts_q[0] <= hupd(x2_q[4], Recip72, Shift72);
      tc_q[0] <= hupd(x2_q[4], Recip90, Shift90);
      ps_q[1] <= qmul(x2_q[5], ts_q[0]);
      pc_q[1] <= qmul(x2_q[5], tc_q[0]);
      ts_q[1] <= hupd(ps_q[1], Recip42, Shift42);
      tc_q[1] <= hupd(pc_q[1], Recip56, Shift56);
      ps_q[2] <= qmul(x2_q[7], ts_q[1]);
      pc_q[2] <= qmul(x2_q[7], tc_q[1]);
      ts_q[2] <= hupd(ps_q[2], Recip20, Shift20);
      tc_q[2] <= hupd(pc_q[2], Recip30, Shift30);
      ps_q[3] <= qmul(x2_q[9], ts_q[2]);
      pc_q[3] <= qmul(x2_q[9], tc_q[2]);
      ts_q[3] <= hupd(ps_q[3], Recip6, Shift6);
      tc_q[3] <= hupd(pc_q[3], Recip12, Shift12);
      // sine times x, cosine last step divides by two
      sv_q <= qmul(x_q[11], ts_q[3]);
      cv_q <= QOne - 31'(qmul(x2_q[11], tc_q[3]) >> 1);
      case (quad_q[12])
        2'd0:    begin sin_q <= s;  cos_q <= c;  end
        2'd1:    begin sin_q <= c;  cos_q <= -s; end
        2'd2:    begin sin_q <= -s; cos_q <= -c; end
        default: begin sin_q <= -c; cos_q <= s;  end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

// ===== rtl/core/euler_rotation_matrix_unit.sv =====
// euler-angle rotation matrix unit, top level
// depends on erm_pkg, erm_sincos and euler_rotation_matrix_unit_assert.svh
//
// Streams one angle triple per cycle into nine Q2.14 matrix elements
// (column-major, Rz*Rx*Ry for req_type 0, Rz*Ry*Rx for req_type 1).
// The sine/cosine pipelines (wrap, fold, radian scale, square, seven
// Horner stages alternating product and reciprocal divide, final
// product, quadrant mapping) are followed by two product stages and
// one output register. The whole pipeline advances on a common
// enable, so a stalled output freezes every stage and a new transfer
// is taken every cycle while the output is free or being taken.
`include "euler_rotation_matrix_unit_assert.svh"
module euler_rotation_matrix_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  erm_pkg::erm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output erm_pkg::erm_out_t out_data_o
);
  import erm_pkg::*;

  localparam int ScDepth = 13;
  localparam int Depth   = ScDepth + 3;

  // pipeline advances when the last stage is empty or being taken
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // valid bits and selector travel with the data
  logic [Depth-1:0] vld_q;
  logic             sel_q [ScDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q[0] <= in_data_i.req_type;
      for (int i = 1; i < ScDepth; i++) sel_q[i] <= sel_q[i-1];
    end
  end

  q30_t sz, cz, sx, cx, sy, cy;

  erm_sincos u_sc_z (.clk_i, .rst_ni, .en_i(en), .angle_i(in_data_i.angle_z),
                     .sin_o(sz), .cos_o(cz));
  erm_sincos u_sc_x (.clk_i, .rst_ni, .en_i(en), .angle_i(in_data_i.angle_x),
                     .sin_o(sx), .cos_o(cx));
  erm_sincos u_sc_y (.clk_i, .rst_ni, .en_i(en), .angle_i(in_data_i.angle_y),
                     .sin_o(sy), .cos_o(cy));

  // product stage 1: all pair products plus carried operands
  q30_t p_cycz_q, p_sxsy_q, p_czsx_q, p_cysz_q, p_cxsy_q, p_cxsz_q, p_cxcz_q;
  q30_t p_czsy_q, p_cysx_q, p_cycz_q2, p_sysz_q, p_cxcy_q, p_szsx_q, p_cxsy2_q;
  q30_t sx1_q, sy1_q, sz1_q;
  logic sel1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cycz_q  <= mulq(cy, cz);
      p_sxsy_q  <= mulq(sx, sy);
      p_czsx_q  <= mulq(cz, sx);
      p_cysz_q  <= mulq(cy, sz);
      p_cxsy_q  <= mulq(cx, sy);
      p_cxsz_q  <= mulq(cx, sz);
      p_cxcz_q  <= mulq(cx, cz);
      p_czsy_q  <= mulq(cz, sy);
      p_cysx_q  <= mulq(cy, sx);
      p_cycz_q2 <= mulq(cy, cz);
      p_sysz_q  <= mulq(sy, sz);
      p_cxcy_q  <= mulq(cx, cy);
      p_szsx_q  <= mulq(sz, sx);
      p_cxsy2_q <= mulq(cx, sy);
      sx1_q     <= sx;
      sy1_q     <= sy;
      sz1_q     <= sz;
      sel1_q    <= sel_q[ScDepth-1];
    end
  end

  // product stage 2: triple products and sums
  q30_t m_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!sel1_q) begin
        m_q[0] <= p_cycz_q - mulq(p_sxsy_q, sz1_q);
        m_q[1] <= mulq(p_czsx_q, sy1_q) + p_cysz_q;
        m_q[2] <= -p_cxsy_q;
        m_q[3] <= -p_cxsz_q;
        m_q[4] <= p_cxcz_q;
        m_q[5] <= sx1_q;
        m_q[6] <= p_czsy_q + mulq(p_cysx_q, sz1_q);
        m_q[7] <= -mulq(p_cycz_q2, sx1_q) + p_sysz_q;
        m_q[8] <= p_cxcy_q;
      end else begin
        m_q[0] <= p_cycz_q;
        m_q[1] <= p_cysz_q;
        m_q[2] <= -sy1_q;
        m_q[3] <= -p_cxsz_q + mulq(p_czsx_q, sy1_q);
        m_q[4] <= p_cxcz_q + mulq(p_sxsy_q, sz1_q);
        m_q[5] <= p_cysx_q;
        m_q[6] <= p_szsx_q + mulq(p_cxcz_q, sy1_q);
        m_q[7] <= -p_czsx_q + mulq(p_cxsy2_q, sz1_q);
        m_q[8] <= p_cxcy_q;
      end
    end
  end

  // output register: round and saturate
  erm_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.col0_row0 <= to_out(m_q[0]);
      out_q.col0_row1 <= to_out(m_q[1]);
      out_q.col0_row2 <= to_out(m_q[2]);
      out_q.col1_row0 <= to_out(m_q[3]);
      out_q.col1_row1 <= to_out(m_q[4]);
      out_q.col1_row2 <= to_out(m_q[5]);
      out_q.col2_row0 <= to_out(m_q[6]);
      out_q.col2_row1 <= to_out(m_q[7]);
      out_q.col2_row2 <= to_out(m_q[8]);
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_data_o  = out_q;

  // a stalled output must freeze the whole pipeline
  `ERM_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i, $stable(vld_q),
                   "pipeline moved during output stall")
  // input is ready whenever the output is not blocked
  `ERM_ASSERT(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i),
              "ready does not follow output stage")
  // an accepted transfer enters the first valid bit
  `ERM_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, vld_q[0],
                   "accepted transfer lost at entry")

endmodule
